/* sv/nec_pkg.sv */
// shared constants and controller/datapath interface types for the echo canceller
package nec_pkg;

  localparam int TAPS   = 256;
  localparam int AW     = $clog2(TAPS);
  localparam int LENW   = 9;
  localparam int STEPW  = 18;
  localparam int WW     = 32;
  localparam int SW     = 16;
  localparam int PWW    = 39;
  localparam int ACCW   = 57;
  localparam int ERRW   = 58;
  localparam int DSRW   = 40;
  localparam int NUMW   = 62;
  localparam int GW     = 47;
  localparam int CNTW   = $clog2(NUMW + 1);

  localparam logic [0:0] REG_TAPS = 1'b0;
  localparam logic [0:0] REG_STEP = 1'b1;

  localparam logic [31:0]  NEAR_FLOOR = 32'd429496;
  localparam logic [PWW-1:0] ENERGY_MIN = PWW'(1073);
  localparam logic [DSRW-1:0] REG_Q30  = DSRW'(107374);
  localparam logic [15:0]  KEEP_COEF  = 16'd62259;
  localparam logic [11:0]  NEW_COEF   = 12'd3277;

  typedef struct packed {
    logic clr;
    logic load_in;
    logic start_fir;
    logic issue;
    logic energy1;
    logic energy2;
    logic decide;
    logic gain;
    logic div_start;
    logic div_step;
    logic start_adapt;
    logic load_out;
  } nec_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic issue_last;
    logic pipe_empty;
    logic div_done;
    logic adapt;
  } nec_sts_t;

endpackage

/* sv/nlms_echo_canceller_unit.sv */
// top level of the nlms acoustic echo canceller
// One word in gives one word out. Each word takes one pass over the delay line and
// weight rams for the filter (one tap a cycle, then a drain of the tap pipeline), the
// energy and error arithmetic, and, when the weights adapt, a bit-serial gain divider
// plus a second pass to update the weights. After reset the block runs a clearing pass
// over all 256 entries of both rams before it takes its first word. The result sits in
// an output register, so the next word is taken while it waits; a held result only
// stalls the following word in its finishing state.
module nlms_echo_canceller_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [0:0]                cfg_index,
  input  logic [nec_pkg::STEPW-1:0] cfg_data,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [31:0]               in_tdata,   // mic_sample[15:0], ref_sample[31:16]
  input  logic                      in_tlast,   // end_of_block
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [15:0]               out_tdata,  // echo_free_sample[15:0]
  output logic                      out_tlast   // end_of_block_out
);
  import nec_pkg::*;

  nec_cmd_t cmd;
  nec_sts_t sts;

  nec_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .cmd(cmd), .sts(sts)
  );

  nec_dp u_dp (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tdata(out_tdata), .out_tlast(out_tlast),
    .cmd(cmd), .sts(sts)
  );

endmodule

/* sv/nec_ram.sv */
// generic simple dual-port ram with registered read
module nec_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/nec_ctrl.sv */
// sequencing state machine for the echo canceller
module nec_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  output nec_pkg::nec_cmd_t cmd,
  input  nec_pkg::nec_sts_t sts
);
  import nec_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_SETUP, S_FIR, S_FIR_DRAIN, S_EN1, S_EN2, S_DECIDE,
    S_GAIN, S_DIV_LD, S_DIV, S_ADAPT_LD, S_ADAPT, S_ADAPT_DRAIN, S_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_free   = !out_valid_r || out_tready;

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          state_nxt = S_SETUP;
        end
      end
      S_SETUP: begin
        cmd.start_fir = 1'b1;
        state_nxt = S_FIR;
      end
      S_FIR: begin
        cmd.issue = 1'b1;
        if (sts.issue_last) state_nxt = S_FIR_DRAIN;
      end
      S_FIR_DRAIN: begin
        if (sts.pipe_empty) state_nxt = S_EN1;
      end
      S_EN1: begin
        cmd.energy1 = 1'b1;
        state_nxt = S_EN2;
      end
      S_EN2: begin
        cmd.energy2 = 1'b1;
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_nxt = S_GAIN;
      end
      S_GAIN: begin
        if (sts.adapt) begin
          cmd.gain = 1'b1;
          state_nxt = S_DIV_LD;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_DIV_LD: begin
        cmd.div_start = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) state_nxt = S_ADAPT_LD;
      end
      S_ADAPT_LD: begin
        cmd.start_adapt = 1'b1;
        state_nxt = S_ADAPT;
      end
      S_ADAPT: begin
        cmd.issue = 1'b1;
        if (sts.issue_last) state_nxt = S_ADAPT_DRAIN;
      end
      S_ADAPT_DRAIN: begin
        if (sts.pipe_empty) state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* sv/nec_dp.sv */
// datapath: delay line, weights, fir and nlms update pipeline, energies, gain divider
module nec_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [0:0]                  cfg_index,
  input  logic [nec_pkg::STEPW-1:0]   cfg_data,
  input  logic [31:0]                 in_tdata,
  input  logic                        in_tlast,
  output logic [15:0]                 out_tdata,
  output logic                        out_tlast,
  input  nec_pkg::nec_cmd_t           cmd,
  output nec_pkg::nec_sts_t           sts
);
  import nec_pkg::*;

  // configuration
  logic [LENW-1:0]  taps_r;
  logic [STEPW-1:0] step_r;
  logic [LENW-1:0]  len, len_m1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      taps_r <= LENW'(TAPS);
      step_r <= STEPW'(6554);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_TAPS: taps_r <= cfg_data[LENW-1:0];
        REG_STEP: step_r <= cfg_data;
        default:  ;
      endcase
    end
  end

  always_comb begin
    if (taps_r == '0)               len = LENW'(1);
    else if (taps_r > LENW'(TAPS))  len = LENW'(TAPS);
    else                            len = taps_r;
  end
  assign len_m1 = len - LENW'(1);

  // input word
  logic signed [SW-1:0] mic_r, ref_r;
  logic                 eob_r;
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      mic_r <= in_tdata[15:0];
      ref_r <= in_tdata[31:16];
      eob_r <= in_tlast;
    end
  end

  // ring slot and walk counters
  logic [AW-1:0]   ring_r;
  logic [LENW-1:0] tap_r;
  logic [AW-1:0]   pos_r;
  logic [LENW-1:0] cur9;
  logic [AW-1:0]   cur;
  logic            mode_adapt_r;

  assign cur9 = {1'b0, ring_r} + LENW'(1);
  assign cur  = (cur9 >= len) ? '0 : cur9[AW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_r <= '0;
      tap_r  <= '0;
    end else if (cmd.clr) begin
      tap_r <= tap_r + LENW'(1);
    end else if (cmd.start_fir) begin
      ring_r <= cur;
      tap_r  <= '0;
    end else if (cmd.start_adapt) begin
      tap_r <= '0;
    end else if (cmd.issue) begin
      tap_r <= tap_r + LENW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_fir) begin
      pos_r        <= cur;
      mode_adapt_r <= 1'b0;
    end else if (cmd.start_adapt) begin
      pos_r        <= ring_r;
      mode_adapt_r <= 1'b1;
    end else if (cmd.issue) begin
      pos_r <= (pos_r == '0) ? len_m1[AW-1:0] : pos_r - AW'(1);
    end
  end

  // memories
  logic            h_we, w_we;
  logic [AW-1:0]   h_waddr, w_waddr;
  logic [SW-1:0]   h_wdata, h_rdata;
  logic [WW-1:0]   w_wdata, w_rdata;
  logic [AW-1:0]   waddr1_r, waddr2_r;
  logic            v1_r, v2_r;
  logic signed [WW-1:0] w_new;

  assign h_we    = cmd.clr || cmd.start_fir;
  assign h_waddr = cmd.clr ? tap_r[AW-1:0] : cur;
  assign h_wdata = cmd.clr ? '0 : ref_r;
  assign w_we    = cmd.clr || (v2_r && mode_adapt_r);
  assign w_waddr = cmd.clr ? tap_r[AW-1:0] : waddr2_r;
  assign w_wdata = cmd.clr ? '0 : w_new;

  nec_ram #(.WIDTH(SW), .DEPTH(TAPS)) u_hist (
    .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
    .raddr(pos_r), .rdata(h_rdata)
  );

  nec_ram #(.WIDTH(WW), .DEPTH(TAPS)) u_wgt (
    .clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
    .raddr(tap_r[AW-1:0]), .rdata(w_rdata)
  );

  // tap pipeline: read, multiply, accumulate or write back
  logic signed [SW+WW-1:0] prod_r;
  logic [2*SW-2:0]         sq_r;
  logic signed [GW+SW-1:0] dprod_r;
  logic signed [WW-1:0]    wold_r;
  logic signed [GW-1:0]    g_r;
  logic signed [ACCW-1:0]  echo_r;
  logic [PWW-1:0]          pw_r;
  logic signed [SW-1:0]    s;
  logic signed [2*SW-1:0]  ssq;
  logic signed [GW+SW-1:0] dbias;
  logic signed [GW+SW-14:0] dd;
  logic signed [GW+SW-12:0] wsum;

  assign s   = h_rdata;
  assign ssq = s * s;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= cmd.issue;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    waddr1_r <= tap_r[AW-1:0];
    waddr2_r <= waddr1_r;
    if (v1_r) begin
      prod_r  <= $signed(w_rdata) * s;
      sq_r    <= ssq[2*SW-2:0];
      dprod_r <= g_r * s;
      wold_r  <= w_rdata;
    end
    if (cmd.start_fir) begin
      echo_r <= '0;
      pw_r   <= '0;
    end else if (v2_r && !mode_adapt_r) begin
      echo_r <= echo_r + ACCW'(prod_r);
      pw_r   <= pw_r + PWW'(sq_r);
    end
  end

  // weight update: d = g*x / 8192 toward zero, saturated sum
  assign dbias = dprod_r + (dprod_r < 0 ? (GW+SW)'(8191) : (GW+SW)'(0));
  assign dd    = dbias[GW+SW-1:13];
  assign wsum  = (GW+SW-11)'(wold_r) + (GW+SW-11)'(dd);
  always_comb begin
    if (wsum > (GW+SW-11)'(32'sh7FFF_FFFF))       w_new = 32'sh7FFF_FFFF;
    else if (wsum < -(GW+SW-11)'(64'sh8000_0000)) w_new = 32'sh8000_0000;
    else                                           w_new = wsum[WW-1:0];
  end

  // energies, error, decision
  logic [31:0]            near_r, far_r;
  logic [47:0]            nk_r, fk_r;
  logic [43:0]            nn_r, fn_r;
  logic signed [ERRW-1:0] err_r;
  logic signed [15:0]     res_r;
  logic signed [31:0]     e28_r;
  logic                   adapt_r;
  logic signed [2*SW-1:0] msq_full, rsq_full;
  logic [2*SW-2:0]        msq, rsq;
  logic [31:0]            msat, rsat;
  logic signed [ERRW-1:0] ebias15, ebias28, lim;
  logic signed [ERRW-16:0] ediv;
  logic signed [ERRW-29:0] rdiv;
  logic                   dt;

  assign msq_full = mic_r * mic_r;
  assign rsq_full = ref_r * ref_r;
  assign msq  = msq_full[2*SW-2:0];
  assign rsq  = rsq_full[2*SW-2:0];
  assign msat = msq[30] ? 32'hFFFF_FFFF : {msq[29:0], 2'b00};
  assign rsat = rsq[30] ? 32'hFFFF_FFFF : {rsq[29:0], 2'b00};

  assign lim     = ERRW'(3) <<< 42;
  assign ebias15 = err_r + (err_r < 0 ? ERRW'(32767) : ERRW'(0));
  assign ediv    = ebias15[ERRW-1:15];
  assign ebias28 = err_r + (err_r < 0 ? ERRW'(28'hFFF_FFFF) : ERRW'(0));
  assign rdiv    = ebias28[ERRW-1:28];
  assign dt      = (near_r > NEAR_FLOOR) && ({2'b00, near_r} > {far_r, 2'b00});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      near_r <= '0;
      far_r  <= '0;
    end else if (cmd.energy2) begin
      near_r <= 32'((49'(nk_r) + 49'(nn_r)) >> 16);
      far_r  <= 32'((49'(fk_r) + 49'(fn_r)) >> 16);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.energy1) begin
      nk_r  <= near_r * KEEP_COEF;
      fk_r  <= far_r * KEEP_COEF;
      nn_r  <= msat * NEW_COEF;
      fn_r  <= rsat * NEW_COEF;
      err_r <= (ERRW'(mic_r) <<< 28) - ERRW'(echo_r);
    end
    if (cmd.energy2) begin
      if (!(err_r > -lim && err_r < lim))  res_r <= mic_r;
      else if (rdiv > 30'sd32767)          res_r <= 16'sh7FFF;
      else if (rdiv < -30'sd32768)         res_r <= 16'sh8000;
      else                                 res_r <= rdiv[15:0];
      if (ediv > 43'sh0_7FFF_FFFF)         e28_r <= 32'sh7FFF_FFFF;
      else if (ediv < -43'sh0_8000_0000)   e28_r <= 32'sh8000_0000;
      else                                 e28_r <= ediv[31:0];
    end
    if (cmd.decide) begin
      adapt_r <= (pw_r > ENERGY_MIN) && !dt;
    end
  end

  // gain: step*e*4096 / (P + reg), restoring division one bit a cycle
  logic signed [STEPW+WW:0] num_r;
  logic [NUMW-1:0]          dvd_r;
  logic [DSRW-1:0]          rem_r, dsr_r;
  logic [CNTW-1:0]          cnt_r;
  logic                     neg_r;
  logic [STEPW+WW-1:0]      nmag;
  logic [DSRW:0]            trial, tdiff;
  logic [GW-1:0]            qg;

  assign nmag  = num_r[STEPW+WW] ? (STEPW+WW)'(-num_r) : num_r[STEPW+WW-1:0];
  assign trial = {rem_r, dvd_r[NUMW-1]};
  assign tdiff = trial - {1'b0, dsr_r};
  assign qg    = dvd_r[GW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.gain) begin
      num_r <= $signed({1'b0, step_r}) * e28_r;
    end
    if (cmd.div_start) begin
      dvd_r <= {nmag, 12'b0};
      rem_r <= '0;
      dsr_r <= DSRW'(pw_r) + REG_Q30;
      cnt_r <= CNTW'(NUMW);
      neg_r <= num_r[STEPW+WW];
    end else if (cmd.div_step) begin
      cnt_r <= cnt_r - CNTW'(1);
      if (!tdiff[DSRW]) begin
        rem_r <= tdiff[DSRW-1:0];
        dvd_r <= {dvd_r[NUMW-2:0], 1'b1};
      end else begin
        rem_r <= trial[DSRW-1:0];
        dvd_r <= {dvd_r[NUMW-2:0], 1'b0};
      end
    end
    if (cmd.start_adapt) begin
      g_r <= neg_r ? -$signed(qg) : $signed(qg);
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_tdata <= res_r;
      out_tlast <= eob_r;
    end
  end

  assign sts.clr_last   = (tap_r[AW-1:0] == AW'(TAPS - 1));
  assign sts.issue_last = (tap_r == len_m1);
  assign sts.pipe_empty = !v1_r && !v2_r;
  assign sts.div_done   = (cnt_r == CNTW'(1));
  assign sts.adapt      = adapt_r;

endmodule
